// ===== src/cldw_pkg.sv =====
package cldw_pkg;

  // display command set
  localparam logic [7:0] SET_ADDR_CMD  = 8'h80;
  localparam logic [7:0] LINE2_OFFSET  = 8'h40;
  localparam logic [7:0] ENTRY_DEC_CMD = 8'h04;
  localparam logic [7:0] ENTRY_INC_CMD = 8'h06;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [3:0] LAST_COLUMN   = 4'd15;

  // request kinds
  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_NUMBER = 2'd1;
  localparam logic [1:0] REQ_GOTO   = 2'd2;
  localparam logic [1:0] REQ_RAW    = 2'd3;

  // decimal conversion sizes
  localparam int NUM_W     = 32;
  localparam int NDIGITS   = 10;
  localparam int BCD_W     = 4 * NDIGITS;
  localparam int BITCNT_W  = $clog2(NUM_W);
  localparam int DIGCNT_W  = $clog2(NDIGITS + 1);

  typedef logic [BCD_W-1:0] bcd_t;

  // go-to command for a row and column
  function automatic logic [7:0] goto_cmd(input logic row, input logic [3:0] col);
    goto_cmd = SET_ADDR_CMD | (row ? LINE2_OFFSET : 8'h00) | {4'h0, col};
  endfunction

  // one double-dabble step: add 3 to every digit of 5 or more
  function automatic bcd_t dabble_adjust(input bcd_t v);
    bcd_t r;
    r = v;
    for (int i = 0; i < NDIGITS; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    dabble_adjust = r;
  endfunction

endpackage

// ===== src/char_lcd_decimal_writer.sv =====
// a character, go-to or raw command is taken in idle; its first bus write then passes
// the sequencer state register and the output register; a number first runs a
// bit-serial binary to bcd conversion; one request at a time, as the input is ready
// only in idle; conversion shifts one bit per cycle; one output register holds each write
// reset: rst_n low on a rising edge clears the sequencer, output valid and the cursor
// to row 0, column 0
module char_lcd_decimal_writer
  import cldw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // payload_byte[7:0], number[39:8], row[40],
                                  // column[44:41], right_to_left[45], zero fill[47:46]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // bus write channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic        out_tuser,  // is_data[0]
  output logic        out_tlast   // last write of the request
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;  // bit-serial double-dabble
  localparam logic [3:0] S_GOTO  = 4'd2;  // requested go-to
  localparam logic [3:0] S_DEC   = 4'd3;  // entry mode: cursor moves left
  localparam logic [3:0] S_SKIP  = 4'd4;  // drop leading zero digits
  localparam logic [3:0] S_DIGIT = 4'd5;  // one data write
  localparam logic [3:0] S_WRAP  = 4'd6;  // go-to after stepping off a line end
  localparam logic [3:0] S_INC   = 4'd7;  // entry mode back to rightward
  localparam logic [3:0] S_RAW   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [7:0]          payload_r, payload_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic                trow_r, trow_nxt;
  logic [3:0]          tcol_r, tcol_nxt;
  logic                rtl_r, rtl_nxt;
  logic                zero_r, zero_nxt;
  logic                more_r, more_nxt;
  bcd_t                bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [DIGCNT_W-1:0] digcnt_r, digcnt_nxt;
  logic                crow_r, crow_nxt;
  logic [3:0]          ccol_r, ccol_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  // write requested by the sequencer this cycle
  logic       emit_req;
  logic [7:0] emit_byte;
  logic       emit_data;
  logic       emit_last;
  logic       can_emit;
  logic       fire;

  // digit handling
  logic       leftward;
  logic [3:0] digit;
  logic       more_now;
  logic       wrap_now;
  logic       need_inc;
  bcd_t       bcd_adj;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_data_r;
  assign out_tlast  = out_last_r;

  // the output register frees up in the same cycle it is taken
  assign can_emit = !out_valid_r || out_tready;
  assign fire     = emit_req && can_emit;

  assign leftward = (kind_r == REQ_NUMBER) && rtl_r;
  assign need_inc = (kind_r == REQ_NUMBER) && rtl_r && !zero_r;
  assign digit    = rtl_r ? bcd_r[3:0] : bcd_r[BCD_W-1 -: 4];
  assign bcd_adj  = dabble_adjust(bcd_r);

  // any digits left after the one going out now
  always_comb begin
    if (kind_r != REQ_NUMBER) begin
      more_now = 1'b0;
    end else if (rtl_r) begin
      more_now = (bcd_r[BCD_W-1:4] != '0);
    end else begin
      more_now = (digcnt_r > DIGCNT_W'(1));
    end
  end

  assign wrap_now = leftward ? (ccol_r == 4'd0) : (ccol_r == LAST_COLUMN);

  // write for the current state
  always_comb begin
    emit_req  = 1'b0;
    emit_byte = 8'h00;
    emit_data = 1'b0;
    emit_last = 1'b0;
    unique case (state_r)
      S_GOTO: begin
        emit_req  = 1'b1;
        emit_byte = goto_cmd(trow_r, tcol_r);
        emit_last = (kind_r == REQ_GOTO);
      end
      S_DEC: begin
        emit_req  = 1'b1;
        emit_byte = ENTRY_DEC_CMD;
      end
      S_DIGIT: begin
        emit_req  = 1'b1;
        emit_data = 1'b1;
        emit_byte = (kind_r == REQ_NUMBER) ? (ASCII_ZERO | {4'h0, digit}) : payload_r;
        emit_last = !wrap_now && !more_now && !need_inc;
      end
      S_WRAP: begin
        emit_req  = 1'b1;
        emit_byte = goto_cmd(!crow_r, leftward ? LAST_COLUMN : 4'd0);
        emit_last = !more_r && !need_inc;
      end
      S_INC: begin
        emit_req  = 1'b1;
        emit_byte = ENTRY_INC_CMD;
        emit_last = 1'b1;
      end
      S_RAW: begin
        emit_req  = 1'b1;
        emit_byte = payload_r;
        emit_last = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    payload_nxt = payload_r;
    num_nxt     = num_r;
    trow_nxt    = trow_r;
    tcol_nxt    = tcol_r;
    rtl_nxt     = rtl_r;
    zero_nxt    = zero_r;
    more_nxt    = more_r;
    bcd_nxt     = bcd_r;
    bitcnt_nxt  = bitcnt_r;
    digcnt_nxt  = digcnt_r;
    crow_nxt    = crow_r;
    ccol_nxt    = ccol_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser;
          payload_nxt = in_tdata[7:0];
          num_nxt     = in_tdata[39:8];
          trow_nxt    = in_tdata[40];
          tcol_nxt    = in_tdata[44:41];
          rtl_nxt     = in_tdata[45];
          bcd_nxt     = '0;
          bitcnt_nxt  = '0;
          digcnt_nxt  = DIGCNT_W'(NDIGITS);
          unique case (in_tuser)
            REQ_CHAR:   state_nxt = S_DIGIT;
            REQ_NUMBER: state_nxt = S_CONV;
            REQ_GOTO:   state_nxt = S_GOTO;
            default:    state_nxt = S_RAW;
          endcase
        end
      end
      S_CONV: begin
        // adjust, then shift in the next binary bit, msb first
        bcd_nxt    = {bcd_adj[BCD_W-2:0], num_r[NUM_W-1]};
        num_nxt    = {num_r[NUM_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == BITCNT_W'(NUM_W - 1)) begin
          zero_nxt  = ({bcd_adj[BCD_W-2:0], num_r[NUM_W-1]} == '0);
          state_nxt = S_GOTO;
        end
      end
      S_GOTO: begin
        if (fire) begin
          crow_nxt = trow_r;
          ccol_nxt = tcol_r;
          if (kind_r == REQ_GOTO) begin
            state_nxt = S_IDLE;
          end else if (rtl_r && !zero_r) begin
            state_nxt = S_DEC;
          end else if (rtl_r) begin
            state_nxt = S_DIGIT;
          end else begin
            state_nxt = S_SKIP;
          end
        end
      end
      S_DEC: begin
        if (fire) begin
          state_nxt = S_DIGIT;
        end
      end
      S_SKIP: begin
        if (bcd_r[BCD_W-1 -: 4] == 4'd0 && digcnt_r > DIGCNT_W'(1)) begin
          bcd_nxt    = {bcd_r[BCD_W-5:0], 4'h0};
          digcnt_nxt = digcnt_r - 1'b1;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (fire) begin
          more_nxt = more_now;
          if (rtl_r) begin
            bcd_nxt = {4'h0, bcd_r[BCD_W-1:4]};
          end else begin
            bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
          end
          digcnt_nxt = digcnt_r - 1'b1;
          if (wrap_now) begin
            state_nxt = S_WRAP;
          end else begin
            ccol_nxt = leftward ? ccol_r - 4'd1 : ccol_r + 4'd1;
            if (more_now) begin
              state_nxt = S_DIGIT;
            end else if (need_inc) begin
              state_nxt = S_INC;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_WRAP: begin
        if (fire) begin
          crow_nxt = !crow_r;
          ccol_nxt = leftward ? LAST_COLUMN : 4'd0;
          if (more_r) begin
            state_nxt = S_DIGIT;
          end else if (need_inc) begin
            state_nxt = S_INC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_INC, S_RAW: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_data_nxt  = emit_data;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      crow_r      <= 1'b0;
      ccol_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    payload_r  <= payload_nxt;
    num_r      <= num_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    rtl_r      <= rtl_nxt;
    zero_r     <= zero_nxt;
    more_r     <= more_nxt;
    bcd_r      <= bcd_nxt;
    bitcnt_r   <= bitcnt_nxt;
    digcnt_r   <= digcnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== verif/tb_char_lcd_decimal_writer.sv =====
module tb_char_lcd_decimal_writer
  import cldw_pkg::*;
();

  // one request as it travels on the input channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [31:0] number;
    logic        row;
    logic [3:0]  col;
    logic        rtl;
  } lcd_req_t;

  // one byte write on the display bus
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       end_of_run;
  } bus_write_t;

  // directed row: request plus up to three hand-written bus writes
  typedef struct packed {
    lcd_req_t         req;
    logic [1:0]       n_typed;
    bus_write_t [2:0] typed;
  } steer_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // payload_byte[7:0], number[39:8], row[40],
                                  // column[44:41], right_to_left[45], zero fill[47:46]
  logic [1:0]  in_tuser   = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // bus_byte[7:0]
  logic        out_tuser;         // is_data[0]
  logic        out_tlast;

  // predictor state: cursor position as the display sees it
  logic        cur_row;
  logic [4:0]  cur_col;

  bus_write_t  run_writes[$];     // writes caused by the request being decoded
  bus_write_t  writes_due[$];     // writes still owed by the block, oldest first
  steer_row_t  steer_table[$];

  int          mismatches    = 0;
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  int          rx_stall_left = 0;
  bus_write_t  want;

  char_lcd_decimal_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // idle length: mostly short, now and then a long stretch
  function automatic int idle_len();
    if ($urandom_range(0, 19) < 16) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic bus_write_t bw(input logic is_data, input logic [7:0] b,
                                    input logic tail);
    bw.is_data    = is_data;
    bw.bus_byte   = b;
    bw.end_of_run = tail;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // set-address command; it also moves the tracked cursor
  task automatic emit_goto(input logic r, input logic [3:0] c);
    logic [7:0] addr;
    addr = SET_ADDR_CMD + (r ? LINE2_OFFSET : 8'h00) + {4'h0, c};
    run_writes.push_back(bw(1'b0, addr, 1'b0));
    cur_row = r;
    cur_col = {1'b0, c};
  endtask

  // data write, then the cursor steps and wraps onto the other line
  task automatic emit_data(input logic [7:0] b, input logic leftward);
    run_writes.push_back(bw(1'b1, b, 1'b0));
    if (!leftward) begin
      if (cur_col + 5'd1 >= 5'd16) begin
        emit_goto(~cur_row, 4'd0);
      end else begin
        cur_col = cur_col + 5'd1;
      end
    end else begin
      if (cur_col == 5'd0) begin
        emit_goto(~cur_row, LAST_COLUMN);
      end else begin
        cur_col = cur_col - 5'd1;
      end
    end
  endtask

  // works out the whole run of bus writes that one request causes
  task automatic decode_request(input lcd_req_t r);
    logic [3:0]  digits[10];
    logic [31:0] n;
    int          nd;
    run_writes.delete();
    case (r.kind)
      REQ_CHAR: begin
        emit_data(r.payload, 1'b0);
      end
      REQ_NUMBER: begin
        emit_goto(r.row, r.col);
        if (r.number == 32'd0) begin
          emit_data(ASCII_ZERO, r.rtl);
        end else begin
          n  = r.number;
          nd = 0;
          while (n != 32'd0) begin
            digits[nd] = 4'(n % 10);
            n          = n / 10;
            nd++;
          end
          if (r.rtl) begin
            // entry mode decrement, digits from the units up, then back to increment
            run_writes.push_back(bw(1'b0, ENTRY_DEC_CMD, 1'b0));
            for (int i = 0; i < nd; i++) begin
              emit_data(ASCII_ZERO + {4'h0, digits[i]}, 1'b1);
            end
            run_writes.push_back(bw(1'b0, ENTRY_INC_CMD, 1'b0));
          end else begin
            for (int i = nd - 1; i >= 0; i--) begin
              emit_data(ASCII_ZERO + {4'h0, digits[i]}, 1'b0);
            end
          end
        end
      end
      REQ_GOTO: begin
        emit_goto(r.row, r.col);
      end
      default: begin
        // raw command leaves the cursor alone
        run_writes.push_back(bw(1'b0, r.payload, 1'b0));
      end
    endcase
    run_writes[run_writes.size() - 1].end_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // holds a request on the channel until the transaction completes
  task automatic send_request(input lcd_req_t r, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {2'b00, r.rtl, r.col, r.row, r.number, r.payload};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stops sending and waits for every owed write to come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (writes_due.size() != 0);
  endtask

  function automatic int tx_gap();
    if (!tx_idle_on || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return idle_len();
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [7:0] payload,
                         input logic [31:0] number, input logic row,
                         input logic [3:0] col, input logic rtl, input int n,
                         input bus_write_t w0, input bus_write_t w1,
                         input bus_write_t w2);
    steer_row_t s;
    s.req     = '{kind, payload, number, row, col, rtl};
    s.n_typed = n[1:0];
    s.typed   = {w2, w1, w0};
    steer_table.push_back(s);
  endtask

  // numbers are weighted towards every digit count, zero and all ones included
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       pick;
    pick      = $urandom_range(0, 9);
    r.kind    = (pick < 2) ? REQ_CHAR : (pick < 7) ? REQ_NUMBER :
                (pick < 9) ? REQ_GOTO : REQ_RAW;
    r.payload = 8'($urandom);
    pick      = $urandom_range(0, 9);
    if (pick == 0) begin
      r.number = 32'd0;
    end else if (pick == 1) begin
      r.number = 32'hFFFF_FFFF;
    end else if (pick < 5) begin
      r.number = $urandom;
    end else begin
      r.number = $urandom >> $urandom_range(1, 31);
    end
    r.row = 1'($urandom_range(0, 1));
    r.col = 4'($urandom_range(0, 15));
    r.rtl = 1'($urandom_range(0, 1));
    return r;
  endfunction

  localparam bus_write_t NO_WR = '0;

  initial begin
    lcd_req_t r;
    steer_row_t s;

    cur_row = 1'b0;
    cur_col = 5'd0;

    // first the hand-picked cases; typed writes assume the cursor that the rows
    // above leave behind, starting from row 0 column 0 out of reset
    add_row(REQ_RAW, 8'h01, 32'd0, 1'b0, 4'd0, 1'b0, 1,
            bw(1'b0, 8'h01, 1'b1), NO_WR, NO_WR);
    // unused fields at their top values must be ignored
    add_row(REQ_CHAR, 8'h41, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b1, 1,
            bw(1'b1, 8'h41, 1'b1), NO_WR, NO_WR);
    add_row(REQ_GOTO, 8'hFF, 32'd0, 1'b1, 4'd15, 1'b0, 1,
            bw(1'b0, 8'hCF, 1'b1), NO_WR, NO_WR);
    // character at the very end of line 2 wraps to the start of line 1
    add_row(REQ_CHAR, 8'hFF, 32'd0, 1'b0, 4'd0, 1'b0, 2,
            bw(1'b1, 8'hFF, 1'b0), bw(1'b0, 8'h80, 1'b1), NO_WR);
    // zero, left to right
    add_row(REQ_NUMBER, 8'h00, 32'd0, 1'b0, 4'd5, 1'b0, 2,
            bw(1'b0, 8'h85, 1'b0), bw(1'b1, 8'h30, 1'b1), NO_WR);
    // zero, right to left from column 0: no entry mode change, wraps back
    add_row(REQ_NUMBER, 8'h00, 32'd0, 1'b1, 4'd0, 1'b1, 3,
            bw(1'b0, 8'hC0, 1'b0), bw(1'b1, 8'h30, 1'b0), bw(1'b0, 8'h8F, 1'b1));
    add_row(REQ_CHAR,   8'h20, 32'd0,          1'b0, 4'd0,  1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'hFFFF_FFFF,  1'b0, 4'd0,  1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'hFFFF_FFFF,  1'b1, 4'd15, 1'b1, 0, NO_WR, NO_WR, NO_WR);
    // leftward wrap between digits
    add_row(REQ_NUMBER, 8'h00, 32'd123,        1'b0, 4'd1,  1'b1, 0, NO_WR, NO_WR, NO_WR);
    // leftward wrap just before the entry mode restore
    add_row(REQ_NUMBER, 8'h00, 32'd7,          1'b0, 4'd0,  1'b1, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'd45,         1'b0, 4'd14, 1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'd9,          1'b1, 4'd15, 1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'd1000000000, 1'b1, 4'd3,  1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'd10,         1'b1, 4'd9,  1'b1, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_NUMBER, 8'h00, 32'd0,          1'b1, 4'd15, 1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_RAW, 8'h00, 32'd0, 1'b0, 4'd0, 1'b0, 1,
            bw(1'b0, 8'h00, 1'b1), NO_WR, NO_WR);
    add_row(REQ_RAW, 8'hFF, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b1, 1,
            bw(1'b0, 8'hFF, 1'b1), NO_WR, NO_WR);
    add_row(REQ_CHAR, 8'h00, 32'd0, 1'b0, 4'd0, 1'b0, 0, NO_WR, NO_WR, NO_WR);
    add_row(REQ_GOTO, 8'h00, 32'd0, 1'b1, 4'd0, 1'b0, 1,
            bw(1'b0, 8'hC0, 1'b1), NO_WR, NO_WR);
    add_row(REQ_GOTO, 8'h00, 32'd0, 1'b0, 4'd15, 1'b1, 1,
            bw(1'b0, 8'h8F, 1'b1), NO_WR, NO_WR);
    add_row(REQ_CHAR, 8'h7E, 32'd0, 1'b0, 4'd0, 1'b0, 0, NO_WR, NO_WR, NO_WR);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer_table[i]) begin
      s = steer_table[i];
      send_request(s.req, tx_gap());
      // the predictor still runs on typed rows so that the cursor stays in step
      decode_request(s.req);
      if (s.n_typed != 2'd0) begin
        for (int k = 0; k < s.n_typed; k++) begin
          writes_due.push_back(s.typed[k]);
        end
      end else begin
        foreach (run_writes[k]) writes_due.push_back(run_writes[k]);
      end
    end

    // sender holds off until the block has caught up
    drain();

    // random part; idling on each side changes every block of requests
    for (int k = 0; k < 308; k++) begin
      if (k % 55 == 0) begin
        tx_idle_on = ((k / 55) % 4 == 0) || ((k / 55) % 4 == 2);
        rx_idle_on = ((k / 55) % 4 == 0) || ((k / 55) % 4 == 1);
      end
      if (k == 140) begin
        drain();
      end
      r = random_request();
      send_request(r, tx_gap());
      decode_request(r);
      foreach (run_writes[j]) writes_due.push_back(run_writes[j]);
    end

    drain();
    // let anything surplus show up before judging
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // bus write side: compare each transaction, then pick the next ready value
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected bus write, actual is_data %b byte %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = writes_due.pop_front();
        if (out_tuser !== want.is_data) begin
          $display("%0t: is_data expected %b actual %b", $time, want.is_data, out_tuser);
          mismatches++;
        end
        if (out_tdata !== want.bus_byte) begin
          $display("%0t: bus_byte expected %h actual %h", $time, want.bus_byte, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.end_of_run) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.end_of_run,
                   out_tlast);
          mismatches++;
        end
      end
    end

    // back-pressure: stalls of random length while enabled
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall_left <= idle_len() - 1;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

endmodule

// ===== sim.f =====
src/cldw_pkg.sv
src/char_lcd_decimal_writer.sv
verif/tb_char_lcd_decimal_writer.sv
